FILE: sv/scf_pkg.sv
// Shared types and constants of the status color fader.
// Holds the status colors, item kinds, register indexes and the microprogram ROM.
// No dependencies.
package scf_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_FORCE   = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OFFLINE  = 2'd0;
    localparam logic [1:0] STATUS_ACTIVE   = 2'd1;
    localparam logic [1:0] STATUS_DEGRADED = 2'd2;
    localparam logic [1:0] STATUS_FALLBACK = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FADE_LONG    = 2'd0;
    localparam logic [1:0] REG_FADE_SHORT   = 2'd1;
    localparam logic [1:0] REG_FADE_INITIAL = 2'd2;

    // Register reset values
    localparam logic [15:0] FADE_LONG_RST    = 16'd250;
    localparam logic [15:0] FADE_SHORT_RST   = 16'd180;
    localparam logic [15:0] FADE_INITIAL_RST = 16'd200;

    localparam logic [16:0] FADE_TIME_MAX = 17'h1FFFF;

    // Microprogram geometry
    localparam int UPC_W = 4;
    localparam int DIV_STEPS = 8;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    // Fixed step addresses
    localparam logic [UPC_W-1:0] UPC_WAIT   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DECODE = 4'd1;
    localparam logic [UPC_W-1:0] UPC_TICK   = 4'd5;
    localparam logic [UPC_W-1:0] UPC_MUL    = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DIV    = 4'd9;
    localparam logic [UPC_W-1:0] UPC_STORE  = 4'd10;
    localparam logic [UPC_W-1:0] UPC_REQ    = 4'd12;
    localparam logic [UPC_W-1:0] UPC_FORCE  = 4'd14;
    localparam logic [UPC_W-1:0] UPC_EMIT   = 4'd15;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD_TIME,
        OP_LOAD_T,
        OP_MUL,
        OP_DIV,
        OP_STORE,
        OP_REQUEST,
        OP_FORCE
    } t_uop;

    // Jump condition of one step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_TICK,
        C_IS_REQ,
        C_IS_FORCE,
        C_FADE_DONE,
        C_DIV_MORE,
        C_CH_MORE,
        C_SAME_STATE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Color of each status, RGBA
    function automatic logic [31:0] status_color(input logic [1:0] st);
        logic [31:0] c;
        case (st)
            STATUS_OFFLINE:  c = 32'hFF0000FF;
            STATUS_ACTIVE:   c = 32'h00FF00FF;
            STATUS_DEGRADED: c = 32'hFFCC00FF;
            default:         c = 32'h0066FFFF;
        endcase
        return c;
    endfunction

    // Control store
    function automatic t_uword urom(input logic [UPC_W-1:0] a);
        t_uword w;
        unique case (a)
            4'd0:    w = '{OP_NOP,      C_NO_INPUT,   UPC_WAIT};
            4'd1:    w = '{OP_NOP,      C_IS_TICK,    UPC_TICK};
            4'd2:    w = '{OP_NOP,      C_IS_REQ,     UPC_REQ};
            4'd3:    w = '{OP_NOP,      C_IS_FORCE,   UPC_FORCE};
            4'd4:    w = '{OP_NOP,      C_ALWAYS,     UPC_EMIT};
            4'd5:    w = '{OP_NOP,      C_FADE_DONE,  UPC_EMIT};
            4'd6:    w = '{OP_ADD_TIME, C_NEVER,      UPC_WAIT};
            4'd7:    w = '{OP_LOAD_T,   C_NEVER,      UPC_WAIT};
            4'd8:    w = '{OP_MUL,      C_NEVER,      UPC_WAIT};
            4'd9:    w = '{OP_DIV,      C_DIV_MORE,   UPC_DIV};
            4'd10:   w = '{OP_STORE,    C_CH_MORE,    UPC_MUL};
            4'd11:   w = '{OP_NOP,      C_ALWAYS,     UPC_EMIT};
            4'd12:   w = '{OP_NOP,      C_SAME_STATE, UPC_EMIT};
            4'd13:   w = '{OP_REQUEST,  C_ALWAYS,     UPC_EMIT};
            4'd14:   w = '{OP_FORCE,    C_NEVER,      UPC_WAIT};
            default: w = '{OP_NOP,      C_OUT_BUSY,   UPC_EMIT};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/status_color_fader.sv
// Status color fader top level: microcoded sequencer and its datapath.
// Depends on scf_pkg for colors, codes and the control store.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: a tick with
//   elapsed time, a status request that fades from the shown color, or a
//   forced status that jumps at once. Output channel (o_out_valid /
//   i_out_stall) returns one beat per item: status, RGBA and fading flag.
//   Configuration writes (i_cfg_valid / o_cfg_ready) set the long, short and
//   initial fade lengths (initial only until a request); they are taken
//   in any cycle, and are meant for times when no item is in flight.
// Timing:
//   One item at a time; o_in_stall is high from acceptance until the result
//   is loaded into the output register. A tick that advances a fade runs
//   four channels one after another, each one multiply and an 8-step
//   restoring divide (one quotient bit per cycle). The result register
//   frees the sequencer while a beat waits; a stalled receiver holds the
//   next result in the emit step.
// Reset:
//   Synchronous, active low: status offline, color FF0000FF, fade length
//   200, registers at 250 / 180 / 200, output empty.
module status_color_fader
    import scf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_new_state,
    input  logic [15:0] i_elapsed,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_fading,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Sequencer state
    logic [UPC_W-1:0]  r_upc;
    logic [UPC_W-1:0]  n_upc;
    t_uword            w_uw;
    logic              w_jump;

    // Latched item
    logic [1:0]        r_kind;
    logic [1:0]        r_ns;
    logic [15:0]       r_el;

    // Fader state
    logic [1:0]        r_status;
    logic [31:0]       r_start;
    logic [31:0]       r_goal;
    logic [31:0]       r_shown;
    logic [16:0]       r_fade_time;
    logic [15:0]       r_fade_len;
    logic              r_requested;
    logic [15:0]       r_long;
    logic [15:0]       r_short;

    // Channel datapath
    logic [1:0]        r_ch;
    logic [15:0]       r_t;
    logic              r_neg;
    logic [23:0]       r_rem;
    logic [7:0]        r_quo;
    logic [DCNT_W-1:0] r_dcnt;

    // Output register
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_busy;
    logic              w_fade_run;
    logic [7:0]        w_s;
    logic [7:0]        w_g;
    logic [7:0]        w_mag;
    logic [23:0]       w_den;
    logic [17:0]       w_sum;
    logic [15:0]       w_req_len;
    logic [7:0]        w_res;

    assign o_in_stall  = (r_upc != UPC_WAIT);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    assign w_accept   = i_in_valid && (r_upc == UPC_WAIT);
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_fade_run = ({1'b0, r_fade_len} > r_fade_time);

    // Channel operands and divide trial
    assign w_s   = r_start[{r_ch, 3'b000} +: 8];
    assign w_g   = r_goal[{r_ch, 3'b000} +: 8];
    assign w_mag = (w_g < w_s) ? (w_s - w_g) : (w_g - w_s);
    assign w_den = 24'(r_fade_len) << r_dcnt;
    assign w_sum = 18'(r_fade_time) + 18'(r_el);
    assign w_res = r_neg ? (w_s - r_quo) : (w_s + r_quo);

    // Fade length for an accepted request; zero counts as one
    always_comb begin
        w_req_len = ((r_status == STATUS_OFFLINE) || (r_ns == STATUS_OFFLINE))
                    ? r_long : r_short;
        if (w_req_len == 16'd0) begin
            w_req_len = 16'd1;
        end
    end

    // Fetch control word and resolve the jump
    always_comb begin
        w_uw = urom(r_upc);
        case (w_uw.cond)
            C_ALWAYS:     w_jump = 1'b1;
            C_NO_INPUT:   w_jump = !i_in_valid;
            C_IS_TICK:    w_jump = (r_kind == KIND_TICK);
            C_IS_REQ:     w_jump = (r_kind == KIND_REQUEST);
            C_IS_FORCE:   w_jump = (r_kind == KIND_FORCE);
            C_FADE_DONE:  w_jump = !w_fade_run;
            C_DIV_MORE:   w_jump = (r_dcnt != '0);
            C_CH_MORE:    w_jump = (r_ch != 2'd3);
            C_SAME_STATE: w_jump = (r_ns == r_status);
            C_OUT_BUSY:   w_jump = w_out_busy;
            default:      w_jump = 1'b0;
        endcase
        n_upc = w_jump ? w_uw.target : r_upc + 1'b1;
    end

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UPC_WAIT;
            r_status    <= STATUS_OFFLINE;
            r_start     <= status_color(STATUS_OFFLINE);
            r_goal      <= status_color(STATUS_OFFLINE);
            r_shown     <= status_color(STATUS_OFFLINE);
            r_fade_time <= '0;
            r_fade_len  <= FADE_INITIAL_RST;
            r_requested <= 1'b0;
            r_long      <= FADE_LONG_RST;
            r_short     <= FADE_SHORT_RST;
            r_ch        <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;

            // Take an item
            if (w_accept) begin
                r_kind <= i_kind;
                r_ns   <= i_new_state;
                r_el   <= i_elapsed;
            end

            // Drop a delivered beat unless the next one is loaded now
            if (r_out_valid && !i_out_stall && (r_upc != UPC_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FADE_LONG:  r_long  <= i_cfg_data;
                    REG_FADE_SHORT: r_short <= i_cfg_data;
                    REG_FADE_INITIAL: begin
                        if (!r_requested) begin
                            r_fade_len <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                        end
                    end
                    default: ;
                endcase
            end

            // Execute the step's datapath operation
            unique case (w_uw.op)
                OP_ADD_TIME: begin
                    r_fade_time <= w_sum[17] ? FADE_TIME_MAX : w_sum[16:0];
                    r_ch        <= '0;
                end
                OP_LOAD_T: begin
                    r_t <= w_fade_run ? r_fade_time[15:0] : r_fade_len;
                end
                OP_MUL: begin
                    r_neg  <= (w_g < w_s);
                    r_rem  <= 24'(w_mag) * 24'(r_t);
                    r_quo  <= '0;
                    r_dcnt <= DCNT_W'(DIV_STEPS - 1);
                end
                OP_DIV: begin
                    if (r_rem >= w_den) begin
                        r_rem         <= r_rem - w_den;
                        r_quo[r_dcnt] <= 1'b1;
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                end
                OP_STORE: begin
                    r_shown[{r_ch, 3'b000} +: 8] <= w_res;
                    r_ch <= r_ch + 1'b1;
                end
                OP_REQUEST: begin
                    r_start     <= r_shown;
                    r_goal      <= status_color(r_ns);
                    r_fade_time <= '0;
                    r_fade_len  <= w_req_len;
                    r_status    <= r_ns;
                    r_requested <= 1'b1;
                end
                OP_FORCE: begin
                    r_status    <= r_ns;
                    r_shown     <= status_color(r_ns);
                    r_start     <= status_color(r_ns);
                    r_goal      <= status_color(r_ns);
                    r_fade_time <= '0;
                end
                default: ;
            endcase

            // Load the result beat once the output register is free
            if ((r_upc == UPC_EMIT) && !w_out_busy) begin
                r_out_valid <= 1'b1;
                o_status    <= r_status;
                o_red       <= r_shown[31:24];
                o_green     <= r_shown[23:16];
                o_blue      <= r_shown[15:8];
                o_alpha     <= r_shown[7:0];
                o_fading    <= w_fade_run;
            end
        end
    end

    // An accepted item always goes to decode next
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_upc == UPC_DECODE))
        else $error("accepted item did not reach decode");

    // A result beat only appears from the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_upc) == UPC_EMIT))
        else $error("result beat raised outside emit step");

    // The divide loop has run all its steps before a channel is stored
    a_div_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_STORE) |-> (r_dcnt == '1))
        else $error("channel stored before divide finished");

    // Fade length never reaches zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fade_len != 16'd0))
        else $error("fade length is zero");

endmodule
